### hdl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared constants, codes and controller/datapath signal groups for the
// positional insert/delete list.
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

  localparam int CAPACITY    = 16;
  localparam int ENTRY_WIDTH = 32;

  localparam int POS_W   = 4;
  localparam int VALUE_W = 32;
  localparam int LEN_W   = 5;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int EXT_W = (ENTRY_WIDTH > VALUE_W) ? ENTRY_WIDTH : VALUE_W;

  typedef logic [1:0] op_t;
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_DELETE = 2'd1;
  localparam op_t OP_CLEAR  = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  typedef struct packed {
    logic list_full;
    logic ins_in_range;
    logic del_in_range;
  } stat_t;

  typedef struct packed {
    logic    load;
    logic    ins;
    logic    del;
    logic    clr;
    status_t status;
  } cmd_t;

endpackage

`default_nettype wire

### hdl/pli_ctrl.sv
// ----------------------------------------------------------------------------
// pli_ctrl
// Handshake controller: decodes the operation against the list condition
// and issues update and result-load commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  pli_pkg::op_t   in_op,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  pli_pkg::stat_t stat,
  output pli_pkg::cmd_t  cmd
);
  import pli_pkg::*;

  typedef enum logic {S_IDLE, S_HOLD} state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE) || out_ready;
  assign out_valid = (state_r == S_HOLD);
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    cmd.load   = accept;
    cmd.status = ST_DONE;
    case (in_op)
      OP_INSERT: begin
        if (stat.list_full) begin
          cmd.status = ST_FULL;
        end else if (!stat.ins_in_range) begin
          cmd.status = ST_RANGE;
        end else begin
          cmd.ins = accept;
        end
      end
      OP_DELETE: begin
        if (!stat.del_in_range) begin
          cmd.status = ST_RANGE;
        end else begin
          cmd.del = accept;
        end
      end
      OP_CLEAR: begin
        cmd.clr = accept;
      end
      default: begin
        cmd.status = ST_DONE;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready && !accept) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/pli_datapath.sv
// ----------------------------------------------------------------------------
// pli_datapath
// Entry registers with parallel shift, entry count and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pli_pkg::cmd_t                 cmd,
  input  logic [pli_pkg::POS_W-1:0]     position,
  input  logic [pli_pkg::VALUE_W-1:0]   entry_value,
  output pli_pkg::stat_t                stat,
  output pli_pkg::status_t              res_status,
  output logic [pli_pkg::VALUE_W-1:0]   res_removed_value,
  output logic [pli_pkg::LEN_W-1:0]     res_list_length,
  output logic                          res_is_empty
);
  import pli_pkg::*;

  logic [ENTRY_WIDTH-1:0] entries_r   [CAPACITY];
  logic [ENTRY_WIDTH-1:0] entries_nxt [CAPACITY];
  logic [ENTRY_WIDTH-1:0] lower       [CAPACITY];
  logic [ENTRY_WIDTH-1:0] upper       [CAPACITY];
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;

  status_t              status_r;
  logic [VALUE_W-1:0]   removed_r;
  logic [VALUE_W-1:0]   removed_nxt;
  logic [LEN_W-1:0]     length_r;
  logic                 empty_r;

  logic [CMP_W-1:0]       pos_cmp;
  logic [CMP_W-1:0]       cnt_cmp;
  logic [IDX_W-1:0]       pos_idx;
  logic [EXT_W-1:0]       in_ext;
  logic [ENTRY_WIDTH-1:0] wr_word;
  logic [EXT_W-1:0]       rd_ext;

  assign pos_cmp = CMP_W'(position);
  assign cnt_cmp = CMP_W'(count_r);
  assign pos_idx = IDX_W'(pos_cmp);
  assign in_ext  = EXT_W'(entry_value);
  assign wr_word = in_ext[ENTRY_WIDTH-1:0];
  assign rd_ext  = EXT_W'(entries_r[pos_idx]);

  assign stat.list_full    = cnt_cmp >= CMP_W'(CAPACITY);
  assign stat.ins_in_range = (pos_cmp <= cnt_cmp) && (pos_cmp < CMP_W'(CAPACITY));
  assign stat.del_in_range = pos_cmp < cnt_cmp;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_nbr
    if (g == 0) begin : g_bot
      assign lower[g] = '0;
    end else begin : g_mid_lo
      assign lower[g] = entries_r[g-1];
    end
    if (g == CAPACITY - 1) begin : g_top
      assign upper[g] = entries_r[g];
    end else begin : g_mid_hi
      assign upper[g] = entries_r[g+1];
    end
  end

  always_comb begin
    logic [CMP_W-1:0] idx;
    for (int i = 0; i < CAPACITY; i++) begin
      idx            = CMP_W'(i);
      entries_nxt[i] = entries_r[i];
      if (cmd.ins) begin
        if (idx == pos_cmp) begin
          entries_nxt[i] = wr_word;
        end else if (idx > pos_cmp && idx <= cnt_cmp) begin
          entries_nxt[i] = lower[i];
        end
      end else if (cmd.del) begin
        if (idx >= pos_cmp && (idx + 1'b1) < cnt_cmp) begin
          entries_nxt[i] = upper[i];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clr) begin
      count_nxt = '0;
    end else if (cmd.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.del) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign removed_nxt = cmd.del ? rd_ext[VALUE_W-1:0] : '0;

  always_ff @(posedge clk) begin
    entries_r <= entries_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r  <= cmd.status;
      removed_r <= removed_nxt;
      length_r  <= LEN_W'(count_nxt);
      empty_r   <= (count_nxt == '0);
    end
  end

  assign res_status        = status_r;
  assign res_removed_value = removed_r;
  assign res_list_length   = length_r;
  assign res_is_empty      = empty_r;

endmodule

`default_nettype wire

### hdl/positional_insert_delete_list.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_list
// Ordered list in a fixed set of entry registers with insert at a position,
// delete from a position and clear; one result per item.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  in_     | input     | in_valid, in_ready, in_op, in_position, in_entry_value
//  out_    | output    | out_valid, out_ready, out_status, out_removed_value,
//          |           | out_list_length, out_is_empty
//
// One item per cycle: every entry compares its index with the position and
// shifts in the same cycle; the result is registered and shown the next cycle.
// in_ready stays high while the result register is empty or being taken.
// A stalled out_ready holds the result and stops new items.
// Reset empties the list and the result register; entry contents stay as is.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_insert_delete_list (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pli_pkg::op_t                in_op,
  input  logic [pli_pkg::POS_W-1:0]   in_position,
  input  logic [pli_pkg::VALUE_W-1:0] in_entry_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pli_pkg::status_t            out_status,
  output logic [pli_pkg::VALUE_W-1:0] out_removed_value,
  output logic [pli_pkg::LEN_W-1:0]   out_list_length,
  output logic                        out_is_empty
);
  import pli_pkg::*;

  stat_t stat;
  cmd_t  cmd;

  pli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pli_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .position          (in_position),
    .entry_value       (in_entry_value),
    .stat              (stat),
    .res_status        (out_status),
    .res_removed_value (out_removed_value),
    .res_list_length   (out_list_length),
    .res_is_empty      (out_is_empty)
  );

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_list_length) <= CAPACITY))
    else $error("list length beyond capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_list_length == '0)))
    else $error("empty flag disagrees with length");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_DONE)) |-> (out_removed_value == '0))
    else $error("failed item returned a value");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives insert, delete, clear and unused operation items into the positional
// list and checks every result against a cycle-free shadow of the list kept
// in the testbench. Random bursts on the item side and a changing stall
// pattern on the result side exercise back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

  import pli_pkg::*;

  localparam op_t OP_UNUSED   = 2'd3;
  localparam int  ITEM_TARGET = 1200;
  localparam int  STALL_LIMIT = 2000;
  localparam int  TAIL_CYCLES = 10;

  typedef struct {
    op_t                op;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
    bit                 hold;
  } list_item_t;

  typedef struct {
    status_t            status;
    logic [VALUE_W-1:0] removed;
    logic [LEN_W-1:0]   length;
    logic               empty;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  op_t                in_op = OP_CLEAR;
  logic [POS_W-1:0]   in_position = '0;
  logic [VALUE_W-1:0] in_entry_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  status_t            out_status;
  logic [VALUE_W-1:0] out_removed_value;
  logic [LEN_W-1:0]   out_list_length;
  logic               out_is_empty;

  list_item_t         send_queue[$];
  list_result_t       results_due[$];
  logic [VALUE_W-1:0] list_words[CAPACITY];
  int                 list_len = 0;
  int                 planned_len = 0;
  int                 items_planned = 0;
  bit                 hold_next = 1'b0;
  int                 error_count = 0;
  bit                 item_taken = 1'b0;
  int                 burst_left = 1;
  int                 gap_left = 0;
  int                 stall_mode = 0;
  int                 stall_count = 0;
  int                 idle_cycles = 0;

  positional_insert_delete_list i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_position       (in_position),
    .in_entry_value    (in_entry_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_list_length   (out_list_length),
    .out_is_empty      (out_is_empty)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic list_result_t apply_list_op(op_t op, logic [POS_W-1:0] pos,
                                                 logic [VALUE_W-1:0] value);
    list_result_t res;
    res.status  = ST_DONE;
    res.removed = '0;
    case (op)
      OP_INSERT: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else if (pos > list_len || pos >= CAPACITY) begin
          res.status = ST_RANGE;
        end else begin
          for (int i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = value;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (pos >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          res.removed = list_words[pos];
          for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    res.length = list_len[LEN_W-1:0];
    res.empty  = (list_len == 0);
    return res;
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic add_item(op_t op, int pos, logic [VALUE_W-1:0] value);
    list_item_t it;
    it.op       = op;
    it.position = pos[POS_W-1:0];
    it.value    = value;
    it.hold     = hold_next;
    hold_next   = 1'b0;
    send_queue.push_back(it);
    items_planned++;
    case (op)
      OP_INSERT: if (planned_len < CAPACITY && pos <= planned_len) planned_len++;
      OP_DELETE: if (pos < planned_len) planned_len--;
      OP_CLEAR:  planned_len = 0;
      default: ;
    endcase
  endtask

  function automatic logic [VALUE_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int rand_position(int limit);
    if ($urandom_range(0, 6) == 0 || limit < 0) return $urandom_range(0, 15);
    return $urandom_range(0, (limit > 15) ? 15 : limit);
  endfunction

  initial begin
    int n;
    int pick;
    add_item(OP_DELETE, 0, '0);
    add_item(OP_DELETE, 15, '1);
    add_item(OP_INSERT, 1, 32'h1234_5678);
    add_item(OP_UNUSED, 5, '1);
    add_item(OP_CLEAR, 0, '0);
    add_item(OP_INSERT, 0, '0);
    add_item(OP_INSERT, 0, '1);
    add_item(OP_INSERT, 2, 32'hA5A5_5A5A);
    add_item(OP_INSERT, 1, 32'h0000_0001);
    add_item(OP_INSERT, 5, 32'h8000_0000);
    add_item(OP_DELETE, 4, '0);
    add_item(OP_UNUSED, 15, '1);
    add_item(OP_DELETE, 1, '1);
    add_item(OP_DELETE, 0, '0);
    add_item(OP_INSERT, 2, 32'h5A5A_A5A5);
    add_item(OP_DELETE, 2, '0);
    add_item(OP_CLEAR, 7, '1);
    add_item(OP_INSERT, 15, '1);
    add_item(OP_DELETE, 0, '0);
    hold_next = 1'b1;
    while (items_planned < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) hold_next = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick <= 2) begin
        while (planned_len < CAPACITY)
          add_item(OP_INSERT, $urandom_range(0, planned_len > 15 ? 15 : planned_len),
                   rand_word());
        repeat ($urandom_range(1, 2)) add_item(OP_INSERT, $urandom_range(0, 15), rand_word());
      end else if (pick <= 5) begin
        while (planned_len > 0)
          add_item(OP_DELETE, $urandom_range(0, planned_len - 1), rand_word());
        add_item(OP_DELETE, $urandom_range(0, 15), rand_word());
      end else if (pick <= 8) begin
        n = $urandom_range(5, 30);
        repeat (n) begin
          pick = $urandom_range(0, 19);
          if (pick < 9)
            add_item(OP_INSERT, rand_position(planned_len), rand_word());
          else if (pick < 18)
            add_item(OP_DELETE, rand_position(planned_len - 1), rand_word());
          else if (pick == 18)
            add_item(OP_CLEAR, $urandom_range(0, 15), rand_word());
          else
            add_item(OP_UNUSED, $urandom_range(0, 15), rand_word());
        end
      end else begin
        repeat ($urandom_range(1, 6))
          add_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 15), rand_word());
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (send_queue.size() != 0 || in_valid || results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  always @(negedge clk) begin : drive_items
    list_item_t nxt;
    if (in_valid && !item_taken) begin
      // hold the item until it is taken
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      in_valid <= 1'b0;
    end else if (rst_n && send_queue.size() != 0 &&
                 !(send_queue[0].hold && results_due.size() != 0)) begin
      nxt = send_queue.pop_front();
      in_valid       <= 1'b1;
      in_op          <= nxt.op;
      in_position    <= nxt.position;
      in_entry_value <= nxt.value;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin : drive_ready
    bit rdy;
    if (stall_count == 0) stall_mode <= $urandom_range(0, 3);
    stall_count <= (stall_count == 49) ? 0 : stall_count + 1;
    case (stall_mode)
      0:       rdy = 1'b1;
      1:       rdy = 1'($urandom_range(0, 1));
      2:       rdy = (stall_count % 4) != 0;
      default: rdy = ($urandom_range(0, 3) == 0);
    endcase
    out_ready <= rdy;
  end

  always @(posedge clk) begin : watch_channels
    list_result_t want;
    if (!rst_n) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with no item outstanding");
        end else begin
          want = results_due.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_removed_value !== want.removed)
            report_mismatch($sformatf("removed_value %h, want %h",
                                      out_removed_value, want.removed));
          if (out_list_length !== want.length)
            report_mismatch($sformatf("list_length %0d, want %0d",
                                      out_list_length, want.length));
          if (out_is_empty !== want.empty)
            report_mismatch($sformatf("is_empty %b, want %b", out_is_empty, want.empty));
        end
      end
      if (in_valid && in_ready)
        results_due.push_back(apply_list_op(in_op, in_position, in_entry_value));
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
